// ===== hdl/ctb_pkg.sv =====
`default_nettype none

package ctb_pkg;

   // ring geometry default
   localparam int RING_SLOTS_DEFAULT = 16;

   // descriptor queue between the front and back parts
   localparam int QUEUE_DEPTH = 2;

   // request direction bit in bmRequestType
   localparam int DIR_IN_POS = 7;

   // trb type codes (dword 3 bits 15:10)
   localparam logic [5:0] TRB_TYPE_SETUP  = 6'd2;
   localparam logic [5:0] TRB_TYPE_DATA   = 6'd3;
   localparam logic [5:0] TRB_TYPE_STATUS = 6'd4;
   localparam logic [5:0] TRB_TYPE_LINK   = 6'd6;

   // transfer type codes for the setup trb
   localparam logic [1:0] TRT_NONE = 2'd0;
   localparam logic [1:0] TRT_OUT  = 2'd2;
   localparam logic [1:0] TRT_IN   = 2'd3;

   // low flag bits of dword 3
   localparam logic [9:0] FLAG_IDT    = 10'h040;
   localparam logic [9:0] FLAG_IOC    = 10'h020;
   localparam logic [9:0] FLAG_TOGGLE = 10'h002;

   localparam logic [31:0] SETUP_LEN = 32'd8;

   // classified control request
   typedef struct packed {
      logic [7:0]  request_type;
      logic [7:0]  request_code;
      logic [15:0] request_value;
      logic [15:0] request_index;
      logic [15:0] data_length;
      logic [63:0] data_address;
      logic [7:0]  device_slot;
      logic        has_data;
      logic        is_in;
   } desc_type;

endpackage

`default_nettype wire

// ===== hdl/ctb_front.sv =====
`default_nettype none

module ctb_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [7:0]         req_request_type,
   input  wire logic [7:0]         req_request_code,
   input  wire logic [15:0]        req_request_value,
   input  wire logic [15:0]        req_request_index,
   input  wire logic [15:0]        req_data_length,
   input  wire logic [63:0]        req_data_address,
   input  wire logic [7:0]         req_device_slot,
   output      logic               out_valid,
   input  wire logic               out_ready,
   output      ctb_pkg::desc_type  out_desc
);

   logic              valid_ff, valid_in;
   ctb_pkg::desc_type desc_ff, desc_in;
   logic              accept;

   assign req_ready = !valid_ff || out_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      desc_in               = desc_ff;
      if (accept) begin
         desc_in.request_type  = req_request_type;
         desc_in.request_code  = req_request_code;
         desc_in.request_value = req_request_value;
         desc_in.request_index = req_request_index;
         desc_in.data_length   = req_data_length;
         desc_in.data_address  = req_data_address;
         desc_in.device_slot   = req_device_slot;
         desc_in.has_data      = |req_data_length;
         desc_in.is_in         = req_request_type[ctb_pkg::DIR_IN_POS];
      end
      if (accept) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      desc_ff <= desc_in;
   end

   assign out_valid = valid_ff;
   assign out_desc  = desc_ff;

endmodule

`default_nettype wire

// ===== hdl/ctb_queue.sv =====
`default_nettype none

module ctb_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output      logic               in_ready,
   input  wire ctb_pkg::desc_type  in_desc,
   output      logic               out_valid,
   input  wire logic               out_ready,
   output      ctb_pkg::desc_type  out_desc
);

   localparam int PTR_W = (ctb_pkg::QUEUE_DEPTH > 1) ? $clog2(ctb_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(ctb_pkg::QUEUE_DEPTH + 1);

   ctb_pkg::desc_type entry_ff [ctb_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign in_ready  = count_ff != CNT_W'(ctb_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_desc  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(ctb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(ctb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_desc;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/ctb_back.sv =====
`default_nettype none

module ctb_back #(
   parameter int RING_SLOTS = ctb_pkg::RING_SLOTS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [63:0]        ring_base,
   input  wire logic               q_valid,
   output      logic               q_ready,
   input  wire ctb_pkg::desc_type  q_desc,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic [63:0]        rsp_trb_address,
   output      logic [31:0]        rsp_word0,
   output      logic [31:0]        rsp_word1,
   output      logic [31:0]        rsp_word2,
   output      logic [31:0]        rsp_word3,
   output      logic               rsp_is_link,
   output      logic [7:0]         rsp_doorbell_slot,
   output      logic               rsp_last
);

   localparam int IDX_W = $clog2(RING_SLOTS);

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_SETUP  = 3'd1;
   localparam logic [2:0] PH_DATA   = 3'd2;
   localparam logic [2:0] PH_STATUS = 3'd3;
   localparam logic [2:0] PH_LINK   = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [2:0]        resume_ff, resume_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              cycle_ff, cycle_in;
   ctb_pkg::desc_type desc_ff, desc_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [63:0]       rsp_addr_ff, rsp_addr_in;
   logic [31:0]       rsp_w0_ff, rsp_w0_in;
   logic [31:0]       rsp_w1_ff, rsp_w1_in;
   logic [31:0]       rsp_w2_ff, rsp_w2_in;
   logic [31:0]       rsp_w3_ff, rsp_w3_in;
   logic              rsp_link_ff, rsp_link_in;
   logic [7:0]        rsp_slot_ff, rsp_slot_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free, emit, wrap;
   logic [2:0]        next_phase;
   logic [1:0]        trt;
   logic [59:0]       base_blk;
   logic [63:0]       slot_addr, link_addr;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = (state_ff != PH_IDLE) && out_free;
   assign wrap      = idx_ff == IDX_W'(RING_SLOTS - 2);
   assign base_blk  = ring_base[63:4];
   assign slot_addr = {base_blk + 60'(idx_ff), 4'b0000};
   assign link_addr = {base_blk + 60'(RING_SLOTS - 1), 4'b0000};
   assign trt       = !desc_ff.has_data ? ctb_pkg::TRT_NONE :
                      (desc_ff.is_in ? ctb_pkg::TRT_IN : ctb_pkg::TRT_OUT);

   always_comb begin
      state_in    = state_ff;
      resume_in   = resume_ff;
      idx_in      = idx_ff;
      cycle_in    = cycle_ff;
      desc_in     = desc_ff;
      q_ready     = 1'b0;
      next_phase  = PH_IDLE;
      rsp_addr_in = slot_addr;
      rsp_w0_in   = '0;
      rsp_w1_in   = '0;
      rsp_w2_in   = '0;
      rsp_w3_in   = '0;
      rsp_link_in = 1'b0;
      rsp_last_in = 1'b0;

      case (state_ff)
         PH_SETUP: begin
            rsp_w0_in  = {desc_ff.request_value, desc_ff.request_code, desc_ff.request_type};
            rsp_w1_in  = {desc_ff.data_length, desc_ff.request_index};
            rsp_w2_in  = ctb_pkg::SETUP_LEN;
            rsp_w3_in  = {14'd0, trt, ctb_pkg::TRB_TYPE_SETUP,
                          ctb_pkg::FLAG_IDT | {9'd0, cycle_ff}};
            next_phase = desc_ff.has_data ? PH_DATA : PH_STATUS;
         end
         PH_DATA: begin
            rsp_w0_in  = desc_ff.data_address[31:0];
            rsp_w1_in  = desc_ff.data_address[63:32];
            rsp_w2_in  = {16'd0, desc_ff.data_length};
            rsp_w3_in  = {15'd0, desc_ff.is_in, ctb_pkg::TRB_TYPE_DATA, {9'd0, cycle_ff}};
            next_phase = PH_STATUS;
         end
         PH_STATUS: begin
            // status runs opposite to the data stage, in when there is none
            rsp_w3_in  = {15'd0, !(desc_ff.has_data && desc_ff.is_in),
                          ctb_pkg::TRB_TYPE_STATUS, ctb_pkg::FLAG_IOC | {9'd0, cycle_ff}};
            next_phase = PH_IDLE;
         end
         PH_LINK: begin
            rsp_addr_in = link_addr;
            rsp_w0_in   = {ring_base[31:4], 4'b0000};
            rsp_w1_in   = ring_base[63:32];
            rsp_w3_in   = {16'd0, ctb_pkg::TRB_TYPE_LINK,
                           ctb_pkg::FLAG_TOGGLE | {9'd0, cycle_ff}};
            rsp_link_in = 1'b1;
            next_phase  = resume_ff;
         end
         default: begin
            next_phase = PH_IDLE;
         end
      endcase

      if (emit) begin
         if (state_ff == PH_LINK) begin
            cycle_in    = !cycle_ff;
            state_in    = resume_ff;
            rsp_last_in = resume_ff == PH_IDLE;
         end else if (wrap) begin
            idx_in    = '0;
            state_in  = PH_LINK;
            resume_in = next_phase;
         end else begin
            idx_in      = idx_ff + 1'b1;
            state_in    = next_phase;
            rsp_last_in = next_phase == PH_IDLE;
         end
      end

      // pick up the next descriptor as soon as the current one finishes
      if (state_in == PH_IDLE && q_valid) begin
         q_ready  = 1'b1;
         desc_in  = q_desc;
         state_in = PH_SETUP;
      end

      rsp_slot_in = rsp_last_in ? desc_ff.device_slot : 8'd0;

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PH_IDLE;
         resume_ff    <= PH_IDLE;
         idx_ff       <= '0;
         cycle_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         resume_ff    <= resume_in;
         idx_ff       <= idx_in;
         cycle_ff     <= cycle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      desc_ff <= desc_in;
      if (emit) begin
         rsp_addr_ff <= rsp_addr_in;
         rsp_w0_ff   <= rsp_w0_in;
         rsp_w1_ff   <= rsp_w1_in;
         rsp_w2_ff   <= rsp_w2_in;
         rsp_w3_ff   <= rsp_w3_in;
         rsp_link_ff <= rsp_link_in;
         rsp_slot_ff <= rsp_slot_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_trb_address   = rsp_addr_ff;
   assign rsp_word0         = rsp_w0_ff;
   assign rsp_word1         = rsp_w1_ff;
   assign rsp_word2         = rsp_w2_ff;
   assign rsp_word3         = rsp_w3_ff;
   assign rsp_is_link       = rsp_link_ff;
   assign rsp_doorbell_slot = rsp_slot_ff;
   assign rsp_last          = rsp_last_ff;

   a_idx_below_link: assert property (@(posedge clock) disable iff (reset)
      idx_ff != IDX_W'(RING_SLOTS - 1))
      else $error("enqueue index reached the link slot");

   a_link_after_wrap: assert property (@(posedge clock) disable iff (reset)
      state_ff == PH_LINK |-> idx_ff == '0)
      else $error("link pending without index wrap");

   a_link_toggles_cycle: assert property (@(posedge clock) disable iff (reset)
      (emit && state_ff == PH_LINK) |=> cycle_ff != $past(cycle_ff))
      else $error("link write did not toggle producer cycle");

   a_pop_starts_setup: assert property (@(posedge clock) disable iff (reset)
      q_ready |=> state_ff == PH_SETUP)
      else $error("descriptor taken without starting setup");

endmodule

`default_nettype wire

// ===== hdl/control_transfer_trb_builder_unit.sv =====
`default_nettype none

// channel   | ports                         | moves
// ----------+-------------------------------+------------------------------------
// request   | req_valid / req_ready         | one control request per transaction
// response  | rsp_valid / rsp_ready         | one trb write per transaction
// config    | csr_write_enable / _data      | ring_base, written with no wait
//
// each request gives two to four trb writes (setup, optional data, status, plus a
// link write when the ring wraps); the back end issues one write per cycle, while
// rsp_ready does not stall it, through its single result register
// the front register and the two-entry descriptor queue let new requests arrive
// while the back end is still emitting or stalled by rsp_ready
// synchronous active-high reset: enqueue index 0, producer cycle 1, ring_base 0

module control_transfer_trb_builder_unit #(
   parameter int RING_SLOTS = ctb_pkg::RING_SLOTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_request_type,
   input  wire logic [7:0]  req_request_code,
   input  wire logic [15:0] req_request_value,
   input  wire logic [15:0] req_request_index,
   input  wire logic [15:0] req_data_length,
   input  wire logic [63:0] req_data_address,
   input  wire logic [7:0]  req_device_slot,
   // response channel
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [63:0] rsp_trb_address,
   output      logic [31:0] rsp_word0,
   output      logic [31:0] rsp_word1,
   output      logic [31:0] rsp_word2,
   output      logic [31:0] rsp_word3,
   output      logic        rsp_is_link,
   output      logic [7:0]  rsp_doorbell_slot,
   output      logic        rsp_last,
   // configuration
   input  wire logic        csr_write_enable,
   input  wire logic [63:0] csr_write_data
);

   // ring base register; the user must change it only while the block is idle, the block does not enforce this
   logic [63:0]       ring_base_ff, ring_base_in;

   // front register to queue
   logic              front_valid, front_ready;
   ctb_pkg::desc_type front_desc;

   // queue to back end
   logic              q_valid, q_ready;
   ctb_pkg::desc_type q_desc;

   assign ring_base_in = csr_write_enable ? csr_write_data : ring_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_base_ff <= '0;
      end else begin
         ring_base_ff <= ring_base_in;
      end
   end

   // accept and classify requests
   ctb_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_request_type  (req_request_type),
      .req_request_code  (req_request_code),
      .req_request_value (req_request_value),
      .req_request_index (req_request_index),
      .req_data_length   (req_data_length),
      .req_data_address  (req_data_address),
      .req_device_slot   (req_device_slot),
      .out_valid         (front_valid),
      .out_ready         (front_ready),
      .out_desc          (front_desc)
   );

   // decouples the front from the trb sequencer
   ctb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_desc   (front_desc),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_desc  (q_desc)
   );

   // trb sequencer, ring index and producer cycle
   ctb_back #(
      .RING_SLOTS (RING_SLOTS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .ring_base         (ring_base_ff),
      .q_valid           (q_valid),
      .q_ready           (q_ready),
      .q_desc            (q_desc),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_trb_address   (rsp_trb_address),
      .rsp_word0         (rsp_word0),
      .rsp_word1         (rsp_word1),
      .rsp_word2         (rsp_word2),
      .rsp_word3         (rsp_word3),
      .rsp_is_link       (rsp_is_link),
      .rsp_doorbell_slot (rsp_doorbell_slot),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

// ===== dv/control_transfer_trb_builder_unit_test.sv =====
module control_transfer_trb_builder_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_SLOTS = ctb_pkg::RING_SLOTS_DEFAULT;
   // cycles with no transaction on either channel before the run is declared hung
   localparam int HANG_LIMIT = 2000;
   // quiet cycles after the last write before the final verdict
   localparam int TAIL_CYCLES = 20;

   // one control request as it goes onto the request channel
   typedef struct packed {
      logic [7:0]  request_type;
      logic [7:0]  request_code;
      logic [15:0] request_value;
      logic [15:0] request_index;
      logic [15:0] data_length;
      logic [63:0] data_address;
      logic [7:0]  device_slot;
   } control_request_type;

   // one trb write as it should appear on the response channel
   typedef struct {
      logic [63:0] trb_address;
      logic [31:0] word0;
      logic [31:0] word1;
      logic [31:0] word2;
      logic [31:0] word3;
      logic        is_link;
      logic [7:0]  doorbell_slot;
      logic        last;
   } trb_write_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_request_type = '0;
   logic [7:0]  req_request_code = '0;
   logic [15:0] req_request_value = '0;
   logic [15:0] req_request_index = '0;
   logic [15:0] req_data_length = '0;
   logic [63:0] req_data_address = '0;
   logic [7:0]  req_device_slot = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_trb_address;
   logic [31:0] rsp_word0;
   logic [31:0] rsp_word1;
   logic [31:0] rsp_word2;
   logic [31:0] rsp_word3;
   logic        rsp_is_link;
   logic [7:0]  rsp_doorbell_slot;
   logic        rsp_last;
   logic        csr_write_enable = 1'b0;
   logic [63:0] csr_write_data = '0;

   // shadow of the ring producer: base register, enqueue slot and cycle bit
   logic [63:0] ring_base_shadow = '0;
   int unsigned enqueue_slot = 0;
   logic        producer_cycle = 1'b1;

   // trb writes predicted but not yet seen, oldest first
   trb_write_type trb_writes_due[$];

   int          mismatch_count = 0;
   int          quiet_cycles = 0;
   // when set, neither side inserts gaps or stalls
   logic        idle_off = 1'b0;

   control_transfer_trb_builder_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_request_type  (req_request_type),
      .req_request_code  (req_request_code),
      .req_request_value (req_request_value),
      .req_request_index (req_request_index),
      .req_data_length   (req_data_length),
      .req_data_address  (req_data_address),
      .req_device_slot   (req_device_slot),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_trb_address   (rsp_trb_address),
      .rsp_word0         (rsp_word0),
      .rsp_word1         (rsp_word1),
      .rsp_word2         (rsp_word2),
      .rsp_word3         (rsp_word3),
      .rsp_is_link       (rsp_is_link),
      .rsp_doorbell_slot (rsp_doorbell_slot),
      .rsp_last          (rsp_last),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // place one trb at the enqueue slot; re-arm the link trb when the ring wraps
   function automatic void place_trb(input logic [31:0] w0, input logic [31:0] w1,
                                     input logic [31:0] w2, input logic [5:0] kind,
                                     input logic [9:0] flags, input logic [15:0] upper);
      trb_write_type t;
      logic [63:0]   base;
      base = {ring_base_shadow[63:4], 4'h0};   // low nibble of the base is ignored
      t.trb_address   = base + 64'(enqueue_slot) * 64'd16;
      t.word0         = w0;
      t.word1         = w1;
      t.word2         = w2;
      t.word3         = {upper, kind, flags[9:1], producer_cycle};
      t.is_link       = 1'b0;
      t.doorbell_slot = '0;
      t.last          = 1'b0;
      trb_writes_due.push_back(t);
      enqueue_slot++;
      if (enqueue_slot >= RING_SLOTS - 1) begin
         // link trb sits in the final slot and carries the cycle before the toggle
         t.trb_address = base + 64'((RING_SLOTS - 1) * 16);
         t.word0       = base[31:0];
         t.word1       = base[63:32];
         t.word2       = '0;
         t.word3       = {16'h0, ctb_pkg::TRB_TYPE_LINK, ctb_pkg::FLAG_TOGGLE[9:1],
                          producer_cycle};
         t.is_link     = 1'b1;
         trb_writes_due.push_back(t);
         enqueue_slot   = 0;
         producer_cycle = ~producer_cycle;
      end
   endfunction

   // setup, optional data and status trbs for one request; the doorbell rides
   // on whatever write comes last, link write included
   function automatic void predict_trb_writes(input control_request_type r);
      logic          is_in;
      logic          has_data;
      logic [1:0]    transfer_type;
      trb_write_type final_write;
      is_in         = r.request_type[ctb_pkg::DIR_IN_POS];
      has_data      = (r.data_length != 16'h0);
      transfer_type = !has_data ? ctb_pkg::TRT_NONE :
                      (is_in ? ctb_pkg::TRT_IN : ctb_pkg::TRT_OUT);
      place_trb({r.request_value, r.request_code, r.request_type},
                {r.data_length, r.request_index}, ctb_pkg::SETUP_LEN,
                ctb_pkg::TRB_TYPE_SETUP, ctb_pkg::FLAG_IDT, {14'h0, transfer_type});
      if (has_data)
         place_trb(r.data_address[31:0], r.data_address[63:32], {16'h0, r.data_length},
                   ctb_pkg::TRB_TYPE_DATA, 10'h0, {15'h0, is_in});
      // status runs opposite to the data stage, in when there is none
      place_trb('0, '0, '0, ctb_pkg::TRB_TYPE_STATUS, ctb_pkg::FLAG_IOC,
                {15'h0, !(has_data && is_in)});
      final_write = trb_writes_due.pop_back();
      final_write.doorbell_slot = r.device_slot;
      final_write.last          = 1'b1;
      trb_writes_due.push_back(final_write);
   endfunction

   // ---------------------------------------------------------------- checking

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // compare every trb write transaction against the oldest prediction
   always @(posedge clock) begin : check_trb_writes
      trb_write_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (trb_writes_due.size() == 0) begin
            $display("%0t: unexpected trb write, actual address %h", $time, rsp_trb_address);
            mismatch_count++;
         end else begin
            want = trb_writes_due.pop_front();
            check_field("trb_address", want.trb_address, rsp_trb_address);
            check_field("word0", 64'(want.word0), 64'(rsp_word0));
            check_field("word1", 64'(want.word1), 64'(rsp_word1));
            check_field("word2", 64'(want.word2), 64'(rsp_word2));
            check_field("word3", 64'(want.word3), 64'(rsp_word3));
            check_field("is_link", 64'(want.is_link), 64'(rsp_is_link));
            check_field("doorbell_slot", 64'(want.doorbell_slot), 64'(rsp_doorbell_slot));
            check_field("last", 64'(want.last), 64'(rsp_last));
         end
      end
   end

   // hang detection: no transaction on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == HANG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, HANG_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // response side: random stall before taking each trb write
   initial begin : trb_write_sink
      int stall;
      forever begin
         stall = idle_off ? 0 : int'($urandom_range(0, 4));
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // ---------------------------------------------------------------- stimulus

   // one request transaction; valid stays high into the next call when there is no gap
   task automatic send_request(input control_request_type r);
      int gap;
      gap = idle_off ? 0 : int'($urandom_range(0, 4));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_request_type  <= r.request_type;
      req_request_code  <= r.request_code;
      req_request_value <= r.request_value;
      req_request_index <= r.request_index;
      req_data_length   <= r.data_length;
      req_data_address  <= r.data_address;
      req_device_slot   <= r.device_slot;
      do @(posedge clock); while (!req_ready);
      predict_trb_writes(r);
   endtask

   // drop valid and hold off until every predicted write has come back
   task automatic wait_ring_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (trb_writes_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ring_base is only rewritten with the block idle
   task automatic write_ring_base(input logic [63:0] value);
      wait_ring_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      ring_base_shadow = value;
   endtask

   function automatic control_request_type make_request(
         input logic [7:0] rtype, input logic [7:0] code, input logic [15:0] value,
         input logic [15:0] index, input logic [15:0] length, input logic [63:0] addr,
         input logic [7:0] slot);
      control_request_type r;
      r.request_type  = rtype;
      r.request_code  = code;
      r.request_value = value;
      r.request_index = index;
      r.data_length   = length;
      r.data_address  = addr;
      r.device_slot   = slot;
      return r;
   endfunction

   // random request: a fair share without data stage, some short, the rest any length
   function automatic control_request_type random_request();
      control_request_type r;
      int                  mix;
      mix = int'($urandom_range(0, 9));
      r.request_type  = 8'($urandom_range(0, 255));
      r.request_code  = 8'($urandom_range(0, 255));
      r.request_value = 16'($urandom_range(0, 65535));
      r.request_index = 16'($urandom_range(0, 65535));
      r.data_address  = {$urandom, $urandom};
      r.device_slot   = 8'($urandom_range(0, 255));
      if (mix < 3)
         r.data_length = 16'h0;
      else if (mix < 6)
         r.data_length = 16'($urandom_range(1, 64));
      else
         r.data_length = 16'($urandom_range(0, 65535));
      return r;
   endfunction

   // hand-picked requests at reset base: every direction with and without data,
   // field extremes, slot zero; the ring wraps part way through
   task automatic test_directed_requests();
      idle_off = 1'b1;
      send_request(make_request(8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 64'h0, 8'h01));
      send_request(make_request(8'h80, 8'h06, 16'h0100, 16'h0000, 16'h0012,
                                64'h0000_0000_1000_0000, 8'h01));
      send_request(make_request(8'h00, 8'h09, 16'h0001, 16'h0000, 16'h0000, 64'h0, 8'h02));
      send_request(make_request(8'h21, 8'h09, 16'h0200, 16'h0000, 16'h0040,
                                64'h0000_0001_2345_6780, 8'h03));
      idle_off = 1'b0;
      send_request(make_request(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1, 8'hFF));
      send_request(make_request(8'h7F, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1, 8'hFF));
      // device-to-host with no data stage, slot zero passed through
      send_request(make_request(8'h80, 8'h00, 16'h0000, 16'h0000, 16'h0000, 64'h0, 8'h00));
      send_request(make_request(8'hAA, 8'h55, 16'hAAAA, 16'h5555, 16'h0001,
                                64'hAAAA_AAAA_AAAA_AAAA, 8'h80));
      send_request(make_request(8'h55, 8'hAA, 16'h5555, 16'hAAAA, 16'h8000,
                                64'h5555_5555_5555_5555, 8'h7F));
      send_request(make_request(8'h80, 8'h06, 16'h0200, 16'h0000, 16'h00FF,
                                64'hFFFF_FFFF_0000_0000, 8'h10));
      send_request(make_request(8'h00, 8'h05, 16'h007F, 16'h0000, 16'h0000, 64'h0, 8'h00));
      send_request(make_request(8'hC0, 8'h01, 16'h1234, 16'h5678, 16'h0002,
                                64'h0000_0000_FFFF_FFFF, 8'h20));
   endtask

   // base at the top of memory (addresses wrap), all-ones unaligned, back to zero
   task automatic test_ring_base_extremes();
      write_ring_base(64'hFFFF_FFFF_FFFF_FFF0);
      repeat (5) send_request(random_request());
      write_ring_base(64'hFFFF_FFFF_FFFF_FFFF);
      repeat (4) send_request(random_request());
      write_ring_base(64'h0);
      repeat (4) send_request(random_request());
   endtask

   // random requests in phases, each with a fresh base, aligned or not
   task automatic test_random_requests();
      logic [63:0] base;
      for (int phase = 0; phase < 4; phase++) begin
         base = {$urandom, $urandom};
         if ($urandom_range(0, 1) == 0)
            base[3:0] = 4'h0;
         write_ring_base(base);
         for (int n = 0; n < 96; n++) begin
            // stretches without any gaps or stalls
            if (n % 32 == 0)
               idle_off = ($urandom_range(0, 3) == 0);
            // now and then let the ring drain completely before going on
            if ($urandom_range(0, 49) == 0)
               wait_ring_idle();
            send_request(random_request());
         end
      end
      idle_off = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_requests();
      test_ring_base_extremes();
      test_random_requests();

      wait_ring_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (trb_writes_due.size() != 0) begin
         $display("%0t: %0d trb writes never arrived", $time, trb_writes_due.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
